// ===== hdl/tpsc_pkg.sv =====
// Shared types and constants for the tone PWM setting calculator.
// No dependencies; imported by tone_pwm_setting_calculator_top.
package tpsc_pkg;

  // Request function codes
  localparam logic [1:0] FUNC_TONE  = 2'd0;
  localparam logic [1:0] FUNC_ON    = 2'd1;
  localparam logic [1:0] FUNC_OFF   = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // Configuration register indexes
  localparam logic CFG_IDX_CLOCK = 1'b0;
  localparam logic CFG_IDX_MODE  = 1'b1;

  // Output modes
  localparam logic MODE_ACTIVE  = 1'b0;
  localparam logic MODE_PASSIVE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [31:0] CLOCK_HZ_RESET = 32'd84000000;
  localparam logic        MODE_RESET     = MODE_PASSIVE;

  // Arithmetic constants
  localparam int          DIV_WIDTH   = 32;
  localparam logic [7:0]  DUTY_MAX    = 8'd100;
  localparam logic [31:0] PCT_DIVISOR = 32'd100;
  localparam logic [31:0] MIN_TICKS   = 32'd2;
  localparam logic [16:0] MAX_COMPARE = 17'h10000;

  // Percent scaling by reciprocal: ceil(2^30 / 100), exact for products below 2^23
  localparam logic [23:0] RECIP_PCT   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] frequency_hz;
    logic [7:0]  duty_percent;
  } tpsc_in_t;

  typedef struct packed {
    logic        status;
    logic [15:0] prescale_value;
    logic [15:0] reload_value;
    logic [16:0] compare_value;
    logic        pin_level;
    logic        sound_on;
  } tpsc_out_t;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_DIV_TICKS  = 8'b0000_0010,
    ST_CHECK      = 8'b0000_0100,
    ST_DIV_RELOAD = 8'b0000_1000,
    ST_MUL        = 8'b0001_0000,
    ST_SCALE      = 8'b0010_0000,
    ST_COMMIT     = 8'b0100_0000,
    ST_DONE       = 8'b1000_0000
  } tpsc_state_t;

endpackage

// ===== hdl/tone_pwm_setting_calculator_top.sv =====
// Top level of the tone PWM setting calculator: sequencer around one shared
// restoring divider plus a reciprocal multiply for the percent. Depends on tpsc_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one request (tone, on, off, query).
//   out_valid/out_ready/out_data return exactly one result per request with
//   the status and the timer prescaler, reload, compare and pin state after
//   the request.
//   cfg_we/cfg_index/cfg_wdata write timer_clock_hz (index 0) and
//   output_mode (index 1); write only while no request is in flight.
// Flow: on, off and query requests, and tone requests rejected up front,
//   go straight to the done state.
//   Tone requests run two 32-step divisions on the shared divider
//   (clock/frequency, ticks/(prescaler+1)), then a multiply by the duty and
//   a reciprocal multiply for /100, then commit. Tone requests with ticks
//   below two after the first division are rejected there.
//   One request is worked at a time; in_ready is high only when idle, so a
//   new request is taken only once the last result has left the sequencer.
// Reset (synchronous, rst_n low): timer registers and pin cleared, clock
//   84 MHz, passive mode, no result pending.
// Stall: a finished result waits in the output register; the next request
//   can be accepted meanwhile and its result is held until the slot frees.
module tone_pwm_setting_calculator_top
  import tpsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tpsc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tpsc_out_t out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Configuration
  logic [31:0] clock_hz_r;
  logic        mode_r;

  // Architectural timer state
  logic [15:0] prescale_r;
  logic [15:0] reload_r;
  logic [16:0] compare_r;
  logic        pin_r;

  // Sequencer and work registers
  tpsc_state_t state_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] dvs_r;
  logic [6:0]  duty_r;
  logic [15:0] pre_r;
  logic [15:0] rel_r;
  logic        err_r;

  // Output register
  logic      out_valid_r;
  tpsc_out_t out_data_r;

  logic        in_fire;
  logic        out_free;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic        q_bit;
  logic [31:0] rem_next;
  logic        div_last;
  logic [31:0] ticks_m1;
  logic [16:0] reload_inc;
  logic [16:0] rel_p1;
  logic [23:0] product;
  logic [47:0] pct_scaled;
  logic        sound_on;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_HZ_RESET;
      mode_r     <= MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_CLOCK: clock_hz_r <= cfg_wdata;
        CFG_IDX_MODE:  mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Shared divider step: one quotient bit per cycle
  assign rem_sh   = {rem_r, quo_r[DIV_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign q_bit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_next = q_bit ? rem_diff[31:0] : rem_sh[31:0];
  assign div_last = (cnt_r == 5'(DIV_WIDTH - 1));

  // Helpers for setup steps
  assign ticks_m1   = quo_r - 32'd1;
  assign reload_inc = {1'b0, reload_r} + 17'd1;
  assign rel_p1     = quo_r[16:0];
  assign product    = {7'd0, rel_p1} * {17'd0, duty_r};
  // product / 100 as multiply and shift; product stays below 2^23
  assign pct_scaled = {24'd0, quo_r[23:0]} * {24'd0, RECIP_PCT};

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prescale_r <= '0;
      reload_r   <= '0;
      compare_r  <= '0;
      pin_r      <= 1'b0;
      cnt_r      <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_data.func)
              FUNC_TONE: begin
                if (mode_r != MODE_PASSIVE || in_data.frequency_hz == '0 ||
                    in_data.duty_percent > DUTY_MAX) begin
                  err_r   <= 1'b1;
                  state_r <= ST_DONE;
                end else begin
                  err_r   <= 1'b0;
                  rem_r   <= '0;
                  quo_r   <= clock_hz_r;
                  dvs_r   <= in_data.frequency_hz;
                  duty_r  <= in_data.duty_percent[6:0];
                  cnt_r   <= '0;
                  state_r <= ST_DIV_TICKS;
                end
              end
              FUNC_ON: begin
                err_r <= 1'b0;
                if (mode_r == MODE_ACTIVE) pin_r <= 1'b1;
                else compare_r <= {1'b0, reload_inc[16:1]};
                state_r <= ST_DONE;
              end
              FUNC_OFF: begin
                err_r <= 1'b0;
                if (mode_r == MODE_ACTIVE) pin_r <= 1'b0;
                else compare_r <= '0;
                state_r <= ST_DONE;
              end
              default: begin
                // query
                err_r   <= 1'b0;
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_DIV_TICKS, ST_DIV_RELOAD: begin
          rem_r <= rem_next;
          quo_r <= {quo_r[DIV_WIDTH-2:0], q_bit};
          cnt_r <= cnt_r + 5'd1;
          if (div_last) begin
            if (state_r == ST_DIV_TICKS) state_r <= ST_CHECK;
            else state_r <= ST_MUL;
          end
        end
        ST_CHECK: begin
          // quo_r holds ticks; prescaler = (ticks-1) >> 16
          if (quo_r < MIN_TICKS) begin
            err_r   <= 1'b1;
            state_r <= ST_DONE;
          end else begin
            pre_r   <= ticks_m1[31:16];
            rem_r   <= '0;
            dvs_r   <= {16'd0, ticks_m1[31:16]} + 32'd1;
            cnt_r   <= '0;
            state_r <= ST_DIV_RELOAD;
          end
        end
        ST_MUL: begin
          // quo_r holds reload+1
          rel_r   <= 16'(rel_p1 - 17'd1);
          quo_r   <= {8'd0, product};
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          // quo_r holds (reload+1)*duty
          quo_r   <= {15'd0, pct_scaled[RECIP_SHIFT +: 17]};
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          prescale_r <= pre_r;
          reload_r   <= rel_r;
          compare_r  <= quo_r[16:0];
          state_r    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result register
  assign sound_on = (mode_r == MODE_ACTIVE) ? pin_r : (compare_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r.status         <= err_r;
      out_data_r.prescale_value <= prescale_r;
      out_data_r.reload_value   <= reload_r;
      out_data_r.compare_value  <= compare_r;
      out_data_r.pin_level      <= pin_r;
      out_data_r.sound_on       <= sound_on;
    end
  end

  // Checks
  a_compare_range: assert property (@(posedge clk) disable iff (!rst_n)
    compare_r <= MAX_COMPARE)
    else $error("compare register out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("ready high right after a request was taken");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_TICKS || state_r == ST_DIV_RELOAD) |-> dvs_r != '0)
    else $error("divider running with zero divisor");

  a_done_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid_r)
    else $error("finished request did not reach the output register");

endmodule

// ===== bench/tb_tone_pwm_setting_calculator_top.sv =====
// Self-checking bench for tone_pwm_setting_calculator_top: a directed table of
// requests and register writes, then random traffic with random stalls on both
// sides, every result checked against a cycle-free model or a typed-in result. Depends on tpsc_pkg.
module tb_tone_pwm_setting_calculator_top;
  import tpsc_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RAND_ITEMS  = 1800;
  localparam int PHASE_ITEMS = 300;

  // Results that can be read off directly: all clear, ok or error
  localparam tpsc_out_t RES_CLEAR     = '0;
  localparam tpsc_out_t RES_ERR_CLEAR = {1'b1, 51'd0};

  typedef enum logic [1:0] {
    ROW_REQUEST,
    ROW_CLOCK,
    ROW_MODE
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    tpsc_in_t    req;
    logic [31:0] cfg_value;
    logic        known;
    tpsc_out_t   known_res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  tpsc_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  tpsc_out_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_IDX_CLOCK;
  logic [31:0] cfg_wdata = '0;

  // Typed-in result travelling with the current request, if any
  logic        row_known = 1'b0;
  tpsc_out_t   row_result = '0;
  logic        calm = 1'b0;

  // Buzzer model state and its configuration
  logic [31:0] clock_hz = CLOCK_HZ_RESET;
  logic        buzz_mode = MODE_RESET;
  logic [15:0] tmr_prescale = '0;
  logic [15:0] tmr_reload = '0;
  logic [16:0] tmr_compare = '0;
  logic        pin_lvl = 1'b0;

  tpsc_out_t   pending_results[$];
  dir_row_t    dir_rows[$];
  int          mismatches = 0;

  tone_pwm_setting_calculator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Apply one request to the buzzer model and return the state it reports
  function automatic tpsc_out_t apply_buzzer_request(tpsc_in_t req);
    tpsc_out_t   res;
    logic [31:0] ticks;
    logic [31:0] pre;
    logic [31:0] rel;
    logic [31:0] cmp;
    res = '0;
    case (req.func)
      FUNC_TONE: begin
        if (buzz_mode != MODE_PASSIVE || req.frequency_hz == 0 ||
            req.duty_percent > DUTY_MAX) begin
          res.status = 1'b1;
        end else begin
          ticks = clock_hz / req.frequency_hz;
          if (ticks < MIN_TICKS) begin
            res.status = 1'b1;
          end else begin
            pre = (ticks - 1) / 32'd65536;
            rel = ticks / (pre + 1) - 1;
            cmp = (rel + 1) * {24'd0, req.duty_percent} / PCT_DIVISOR;
            tmr_prescale = pre[15:0];
            tmr_reload   = rel[15:0];
            tmr_compare  = cmp[16:0];
          end
        end
      end
      FUNC_ON: begin
        if (buzz_mode == MODE_ACTIVE) begin
          pin_lvl = 1'b1;
        end else begin
          cmp = ({16'd0, tmr_reload} + 1) / 2;
          tmr_compare = cmp[16:0];
        end
      end
      FUNC_OFF: begin
        if (buzz_mode == MODE_ACTIVE) begin
          pin_lvl = 1'b0;
        end else begin
          tmr_compare = '0;
        end
      end
      default: ;
    endcase
    res.prescale_value = tmr_prescale;
    res.reload_value   = tmr_reload;
    res.compare_value  = tmr_compare;
    res.pin_level      = pin_lvl;
    res.sound_on       = (buzz_mode == MODE_ACTIVE) ? pin_lvl : (tmr_compare != 0);
    return res;
  endfunction

  function automatic dir_row_t req_row(logic [1:0] f, logic [31:0] hz, logic [7:0] duty,
                                       logic known, tpsc_out_t res);
    dir_row_t r;
    r.kind = ROW_REQUEST;
    r.req.func = f;
    r.req.frequency_hz = hz;
    r.req.duty_percent = duty;
    r.cfg_value = '0;
    r.known = known;
    r.known_res = res;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(row_kind_t kind, logic [31:0] value);
    dir_row_t r;
    r.kind = kind;
    r.req = '0;
    r.cfg_value = value;
    r.known = 1'b0;
    r.known_res = '0;
    return r;
  endfunction

  function automatic tpsc_in_t rand_request();
    tpsc_in_t req;
    int       pick;
    req.frequency_hz = $urandom();
    req.duty_percent = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 45) begin
      req.func = FUNC_TONE;
    end else if (pick < 62) begin
      req.func = FUNC_ON;
    end else if (pick < 80) begin
      req.func = FUNC_OFF;
    end else begin
      req.func = FUNC_QUERY;
    end
    if (req.func == FUNC_TONE) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        req.frequency_hz = 0;
      end else if (pick < 30) begin
        req.frequency_hz = $urandom_range(1, 1000);
      end else if (pick < 70) begin
        req.frequency_hz = $urandom_range(20, 20000);
      end else if (pick < 85) begin
        // lands ticks near a chosen value, prescaler boundaries included
        req.frequency_hz = clock_hz / $urandom_range(2, 70000);
      end
      if ($urandom_range(9) != 0) begin
        req.duty_percent = 8'($urandom_range(100));
      end
    end
    return req;
  endfunction

  // Offer one request, optionally after an idle gap, and wait for acceptance
  task automatic push_request(tpsc_in_t req, logic known, tpsc_out_t res);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= req;
    row_known  <= known;
    row_result <= res;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Hold off new requests until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_CLOCK) begin
      clock_hz = value;
    end else begin
      buzz_mode = value[0];
    end
    @(posedge clk);
  endtask

  // Output ready: random stalls except during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 29);
  end

  // Result check against the oldest expectation, then log accepted requests
  always @(posedge clk) begin : scoreboard
    tpsc_out_t want;
    tpsc_out_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: st=%0d pre=%0d rel=%0d cmp=%0d pin=%0d on=%0d",
                     got.status, got.prescale_value, got.reload_value,
                     got.compare_value, got.pin_level, got.sound_on);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status ||
              got.prescale_value !== want.prescale_value ||
              got.reload_value !== want.reload_value ||
              got.compare_value !== want.compare_value ||
              got.pin_level !== want.pin_level ||
              got.sound_on !== want.sound_on) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: st=%0d pre=%0d rel=%0d cmp=%0d pin=%0d on=%0d",
                       want.status, want.prescale_value, want.reload_value,
                       want.compare_value, want.pin_level, want.sound_on);
              $display("         got: st=%0d pre=%0d rel=%0d cmp=%0d pin=%0d on=%0d",
                       got.status, got.prescale_value, got.reload_value,
                       got.compare_value, got.pin_level, got.sound_on);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        got = apply_buzzer_request(in_data);
        pending_results.push_back(row_known ? row_result : got);
      end
    end
  end

  // Stimulus
  initial begin
    tpsc_in_t req;
    // reset settings: 84 MHz clock, passive buzzer
    dir_rows.push_back(req_row(FUNC_QUERY, 32'd0, 8'd0, 1'b1, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_ON, 32'd0, 8'd0, 1'b1, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd0, 8'd50, 1'b1, RES_ERR_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd1000, 8'd101, 1'b1, RES_ERR_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'hFFFF_FFFF, 8'd50, 1'b1, RES_ERR_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd84000000, 8'd50, 1'b1, RES_ERR_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd42000000, 8'd100, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd1, 8'd100, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd1000, 8'd0, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_ON, 32'hFFFF_FFFF, 8'hFF, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_OFF, 32'd0, 8'd0, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd1000, 8'd255, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_QUERY, 32'hFFFF_FFFF, 8'hFF, 1'b0, RES_CLEAR));
    // fastest clock: the prescaler reaches its top
    dir_rows.push_back(cfg_row(ROW_CLOCK, 32'hFFFF_FFFF));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd1, 8'd100, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd65536, 8'd37, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_ON, 32'd0, 8'd0, 1'b0, RES_CLEAR));
    // slowest clock: ticks always below two
    dir_rows.push_back(cfg_row(ROW_CLOCK, 32'd1));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd1, 8'd50, 1'b0, RES_CLEAR));
    // active buzzer: tone refused, pin follows on and off
    dir_rows.push_back(cfg_row(ROW_MODE, {31'd0, MODE_ACTIVE}));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd1000, 8'd50, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_ON, 32'd0, 8'd0, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_QUERY, 32'd0, 8'd0, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_OFF, 32'd0, 8'd0, 1'b0, RES_CLEAR));
    // back to passive: registers kept across the mode change
    dir_rows.push_back(cfg_row(ROW_MODE, {31'd0, MODE_PASSIVE}));
    dir_rows.push_back(cfg_row(ROW_CLOCK, CLOCK_HZ_RESET));
    dir_rows.push_back(req_row(FUNC_QUERY, 32'd0, 8'd0, 1'b0, RES_CLEAR));
    dir_rows.push_back(req_row(FUNC_TONE, 32'd440, 8'd50, 1'b0, RES_CLEAR));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REQUEST) begin
        push_request(dir_rows[i].req, dir_rows[i].known, dir_rows[i].known_res);
      end else begin
        drain_results();
        write_reg(dir_rows[i].kind == ROW_CLOCK ? CFG_IDX_CLOCK : CFG_IDX_MODE,
                  dir_rows[i].cfg_value);
      end
    end

    // random traffic, new clock and mode every phase
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        drain_results();
        case ($urandom_range(5))
          0: write_reg(CFG_IDX_CLOCK, CLOCK_HZ_RESET);
          1: write_reg(CFG_IDX_CLOCK, 32'd16000000);
          2: write_reg(CFG_IDX_CLOCK, $urandom_range(1, 100000));
          3: write_reg(CFG_IDX_CLOCK, 32'hFFFF_FFFF);
          default: write_reg(CFG_IDX_CLOCK, $urandom() | 32'd1);
        endcase
        write_reg(CFG_IDX_MODE, {31'd0, ($urandom_range(99) < 80) ? MODE_PASSIVE
                                                                  : MODE_ACTIVE});
      end
      calm <= (n >= 700 && n < 1000);
      req = rand_request();
      push_request(req, 1'b0, RES_CLEAR);
    end

    // wrap up: all results in, then a quiet tail for stray results
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (120) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * 1000000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tpsc_pkg.sv
hdl/tone_pwm_setting_calculator_top.sv
bench/tb_tone_pwm_setting_calculator_top.sv
